[rtl/wpdd_pkg.sv]
// Shared types, register codes and constants of the weighted PID drive controller.
package wpdd_pkg;

	localparam int REG_IDX_W  = 3;
	localparam int MAG_W      = 34;
	localparam int GAIN_W     = 32;
	localparam int PROD_W     = 64;
	localparam int QUOT_W     = 34;
	localparam int DIV_CNT_W  = 6;

	localparam logic [DIV_CNT_W-1:0] DIV_STEPS = 6'd34;
	localparam logic [31:0] WEIGHT_ONE = 32'd65536;

	localparam logic [REG_IDX_W-1:0] REG_GAIN_PROP   = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_GAIN_INTEG  = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_GAIN_DERIV  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_REAR_WEIGHT = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_FRONT_SCALE = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_BACK_SCALE  = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_MAX_SPEED   = 3'd6;

	typedef struct packed {
		logic signed [31:0] gain_prop;
		logic signed [31:0] gain_integ;
		logic signed [31:0] gain_deriv;
		logic        [30:0] rear_weight;
		logic signed [31:0] front_scale;
		logic signed [31:0] back_scale;
		logic signed [31:0] max_speed;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		gain_prop:   32'sd65536,
		gain_integ:  32'sd0,
		gain_deriv:  32'sd0,
		rear_weight: 31'd65536,
		front_scale: 32'sd65536,
		back_scale:  32'sd65536,
		max_speed:   32'sd6553600
	};

	typedef struct packed {
		logic signed [31:0] front_left_err;
		logic signed [31:0] front_right_err;
		logic signed [31:0] rear_left_err;
		logic signed [31:0] rear_right_err;
		logic               forward_dir;
		logic signed [31:0] nominal_speed;
	} item_t;

	typedef struct packed {
		logic signed [31:0] left_speed;
		logic signed [31:0] right_speed;
	} res_t;

	typedef struct packed {
		logic              start;
		logic [MAG_W-1:0]  a;
		logic [GAIN_W-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic              start;
		logic [PROD_W-1:0] dividend;
		logic [31:0]       divisor;
	} div_req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WMUL,
		ST_DIV,
		ST_PMUL,
		ST_IMUL,
		ST_DMUL,
		ST_TMUL,
		ST_OUT
	} state_t;

endpackage

[rtl/wpdd_ifs.sv]
// Channel interfaces of the weighted PID drive controller: sensor items, wheel items, config writes.
interface wpdd_sensor_if import wpdd_pkg::*; ();
	logic               valid;
	logic               ready;
	logic signed [31:0] front_left_err;
	logic signed [31:0] front_right_err;
	logic signed [31:0] rear_left_err;
	logic signed [31:0] rear_right_err;
	logic               forward_dir;
	logic signed [31:0] nominal_speed;

	modport source (
		output valid, front_left_err, front_right_err, rear_left_err, rear_right_err,
		output forward_dir, nominal_speed,
		input  ready
	);
	modport sink (
		input  valid, front_left_err, front_right_err, rear_left_err, rear_right_err,
		input  forward_dir, nominal_speed,
		output ready
	);
endinterface

interface wpdd_wheel_if import wpdd_pkg::*; ();
	logic               valid;
	logic               ready;
	logic signed [31:0] left_speed;
	logic signed [31:0] right_speed;

	modport source (output valid, left_speed, right_speed, input ready);
	modport sink (input valid, left_speed, right_speed, output ready);
endinterface

interface wpdd_cfg_if import wpdd_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [REG_IDX_W-1:0] reg_index;
	logic [31:0]          wr_data;

	modport source (output valid, reg_index, wr_data, input ready);
	modport sink (input valid, reg_index, wr_data, output ready);
endinterface

[rtl/wpdd_mul.sv]
// Shared magnitude multiplier: 34 x 32 bits in two passes of a 17 x 32 partial product.
module wpdd_mul import wpdd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  mul_req_t          req,
	output logic              done,
	output logic [PROD_W-1:0] prod
);

	logic [MAG_W-1:0]  a_q;
	logic [GAIN_W-1:0] b_q;
	logic              busy_q;
	logic              hi_q;
	logic              done_q;
	logic [PROD_W-1:0] acc_q;
	logic [16:0]       a_part;
	logic [48:0]       pp;
	logic [PROD_W-1:0] pp_w;

	assign a_part = hi_q ? a_q[33:17] : a_q[16:0];
	assign pp     = 49'(a_part) * 49'(b_q);
	assign pp_w   = {15'd0, pp};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			hi_q   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				hi_q   <= 1'b0;
			end else if (busy_q) begin
				if (hi_q) begin
					busy_q <= 1'b0;
					hi_q   <= 1'b0;
					done_q <= 1'b1;
				end else begin
					hi_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q <= req.a;
			b_q <= req.b;
		end else if (busy_q) begin
			// low half first, then add the high half shifted into place
			if (hi_q)
				acc_q <= acc_q + (pp_w << 17);
			else
				acc_q <= pp_w;
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

[rtl/wpdd_div.sv]
// Restoring divider, one quotient bit per cycle, for the weighted error average.
module wpdd_div import wpdd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  div_req_t          req,
	output logic              done,
	output logic [QUOT_W-1:0] quot
);

	logic [31:0]          rem_q;
	logic [QUOT_W-1:0]    sh_q;
	logic [31:0]          den_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [32:0]          trial;
	logic [32:0]          diff;
	logic                 ge;

	assign trial = {rem_q, sh_q[QUOT_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_STEPS;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// quotient is below 2^34, so the top dividend bits start as the remainder
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= {2'b00, req.dividend[PROD_W-1:QUOT_W]};
			sh_q  <= req.dividend[QUOT_W-1:0];
			den_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[31:0] : trial[31:0];
			sh_q  <= {sh_q[QUOT_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = sh_q;

endmodule

[rtl/wpdd_ctrl.sv]
// Sequencer and datapath registers: steps one item through the shared multiplier and divider.
module wpdd_ctrl import wpdd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic              item_valid,
	input  item_t             item,
	output logic              item_ready,
	output logic              res_valid,
	output res_t              res,
	input  logic              res_ready,
	output mul_req_t          mul_req,
	input  logic              mul_done,
	input  logic [PROD_W-1:0] mul_prod,
	output div_req_t          div_req,
	input  logic              div_done,
	input  logic [QUOT_W-1:0] div_quot
);

	function automatic logic [MAG_W-1:0] mag34(input logic signed [MAG_W-1:0] v);
		logic [MAG_W-1:0] r;
		r = v[MAG_W-1] ? MAG_W'(-v) : MAG_W'(v);
		return r;
	endfunction

	function automatic logic [31:0] mag32(input logic signed [31:0] v);
		logic [31:0] r;
		r = v[31] ? 32'(-v) : 32'(v);
		return r;
	endfunction

	function automatic logic signed [49:0] mulq_fix(input logic [PROD_W-1:0] p, input logic neg);
		logic signed [49:0] m;
		m = $signed({2'b00, p[PROD_W-1:16]});
		return neg ? -m : m;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [50:0] v);
		logic signed [31:0] r;
		r = v[31:0];
		if (!v[50] && (|v[49:31]))
			r = 32'sh7FFFFFFF;
		else if (v[50] && !(&v[49:31]))
			r = 32'sh80000000;
		return r;
	endfunction

	function automatic logic signed [31:0] clamp_speed(input logic signed [50:0] x,
			input logic signed [31:0] top, input logic signed [31:0] nom);
		logic signed [50:0] y;
		y = (x > 51'(top)) ? 51'(top) : x;
		y = (y < 51'(nom)) ? 51'(nom) : y;
		return y[31:0];
	endfunction

	state_t state_q, state_d;
	logic   issued_q;
	logic   use_mul, use_div;
	logic   mul_neg;

	logic signed [32:0] f_q;
	logic signed [33:0] diff_q;
	logic signed [31:0] nom_q;
	logic               fwd_q;
	logic signed [32:0] avg_q;
	logic signed [31:0] prop_q;
	logic signed [31:0] pid_q;
	logic signed [49:0] tot_q;
	logic signed [31:0] last_q;
	logic signed [31:0] integ_q;

	logic signed [32:0] f_sum, r_sum;
	logic signed [34:0] part;
	logic signed [32:0] dp;
	logic signed [31:0] scale;
	logic signed [49:0] mq;
	logic signed [50:0] t2;

	assign f_sum = 33'(item.front_left_err) + 33'(item.front_right_err);
	assign r_sum = 33'(item.rear_left_err) + 33'(item.rear_right_err);
	assign part  = diff_q[33] ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot});
	assign dp    = 33'(prop_q) - 33'(last_q);
	assign scale = fwd_q ? cfg.front_scale : cfg.back_scale;
	assign mq    = mulq_fix(mul_prod, mul_neg);
	assign t2    = 51'(tot_q) <<< 1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			issued_q <= 1'b0;
			last_q   <= '0;
			integ_q  <= '0;
		end else begin
			state_q <= state_d;
			if (mul_req.start || div_req.start)
				issued_q <= 1'b1;
			else if (mul_done || div_done)
				issued_q <= 1'b0;
			if (state_q == ST_IMUL && mul_done)
				integ_q <= sat32(51'(integ_q) + 51'(mq));
			if (state_q == ST_DMUL && mul_done)
				last_q <= prop_q;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					f_q    <= f_sum;
					diff_q <= 34'(r_sum) - 34'(f_sum);
					nom_q  <= item.nominal_speed;
					fwd_q  <= item.forward_dir;
				end
			end
			ST_DIV: begin
				if (div_done)
					avg_q <= 33'(35'(f_q) + part);
			end
			ST_PMUL: begin
				if (mul_done)
					prop_q <= sat32(51'(mq));
			end
			ST_DMUL: begin
				if (mul_done)
					pid_q <= sat32(51'(prop_q) + 51'(integ_q) + 51'(mq));
			end
			ST_TMUL: begin
				if (mul_done)
					tot_q <= mq;
			end
			default: ;
		endcase
	end

	always_comb begin
		state_d    = state_q;
		mul_req    = '0;
		div_req    = '0;
		use_mul    = 1'b0;
		use_div    = 1'b0;
		mul_neg    = 1'b0;
		item_ready = 1'b0;
		res_valid  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid)
					state_d = ST_WMUL;
			end
			ST_WMUL: begin
				use_mul   = 1'b1;
				mul_req.a = mag34(diff_q);
				mul_req.b = {1'b0, cfg.rear_weight};
				mul_neg   = diff_q[33];
				if (mul_done)
					state_d = ST_DIV;
			end
			ST_DIV: begin
				// divide w*|F-R| by 1.0 + w; the product stays held in the multiplier
				use_div          = 1'b1;
				div_req.dividend = mul_prod;
				div_req.divisor  = {1'b0, cfg.rear_weight} + WEIGHT_ONE;
				if (div_done)
					state_d = ST_PMUL;
			end
			ST_PMUL: begin
				use_mul   = 1'b1;
				mul_req.a = mag34(34'(avg_q));
				mul_req.b = mag32(cfg.gain_prop);
				mul_neg   = avg_q[32] ^ cfg.gain_prop[31];
				if (mul_done)
					state_d = ST_IMUL;
			end
			ST_IMUL: begin
				use_mul   = 1'b1;
				mul_req.a = mag34(34'(last_q));
				mul_req.b = mag32(cfg.gain_integ);
				mul_neg   = last_q[31] ^ cfg.gain_integ[31];
				if (mul_done)
					state_d = ST_DMUL;
			end
			ST_DMUL: begin
				use_mul   = 1'b1;
				mul_req.a = mag34(34'(dp));
				mul_req.b = mag32(cfg.gain_deriv);
				mul_neg   = dp[32] ^ cfg.gain_deriv[31];
				if (mul_done)
					state_d = ST_TMUL;
			end
			ST_TMUL: begin
				use_mul   = 1'b1;
				mul_req.a = mag34(34'(pid_q));
				mul_req.b = mag32(scale);
				mul_neg   = pid_q[31] ^ scale[31];
				if (mul_done)
					state_d = ST_OUT;
			end
			ST_OUT: begin
				res_valid = 1'b1;
				if (res_ready)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
		mul_req.start = use_mul && !issued_q;
		div_req.start = use_div && !issued_q;
	end

	assign res.left_speed  = clamp_speed(51'(nom_q) - t2, cfg.max_speed, nom_q);
	assign res.right_speed = clamp_speed(51'(nom_q) + t2, cfg.max_speed, nom_q);

endmodule

[rtl/weighted_pid_differential_drive_top.sv]
// Top level of the weighted PID differential drive controller.
//
//   channel  dir  handshake      payload
//   sensor   in   valid/ready    four errors, forward_dir, nominal_speed
//   wheel    out  valid/ready    left_speed, right_speed
//   cfg      in   valid/ready    reg_index, wr_data (always ready)
//
// An item is accepted only while the sequencer is idle; its time until the next acceptance
// is spent almost wholly in five passes through the two-pass shared multiplier and in the
// 34-step restoring divider.
// The result goes to an output register; the next item is accepted while it waits.
// A stalled wheel channel holds the sequencer at its last step once the output is full.
// Reset (arst_n low) clears the PID state and loads the register defaults.
module weighted_pid_differential_drive_top import wpdd_pkg::*; (
	input logic          clk,
	input logic          arst_n,
	wpdd_sensor_if.sink  sensor,
	wpdd_wheel_if.source wheel,
	wpdd_cfg_if.sink     cfg
);

	cfg_t     cfg_q;
	item_t    item;
	res_t     res;
	logic     item_ready;
	logic     res_valid;
	logic     slot_free;
	mul_req_t mul_req;
	logic     mul_done;
	logic [PROD_W-1:0] mul_prod;
	div_req_t div_req;
	logic     div_done;
	logic [QUOT_W-1:0] div_quot;

	logic               out_valid_q;
	logic signed [31:0] left_q;
	logic signed [31:0] right_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg.valid) begin
			case (cfg.reg_index)
				REG_GAIN_PROP:   cfg_q.gain_prop   <= $signed(cfg.wr_data);
				REG_GAIN_INTEG:  cfg_q.gain_integ  <= $signed(cfg.wr_data);
				REG_GAIN_DERIV:  cfg_q.gain_deriv  <= $signed(cfg.wr_data);
				REG_REAR_WEIGHT: cfg_q.rear_weight <= cfg.wr_data[30:0];
				REG_FRONT_SCALE: cfg_q.front_scale <= $signed(cfg.wr_data);
				REG_BACK_SCALE:  cfg_q.back_scale  <= $signed(cfg.wr_data);
				REG_MAX_SPEED:   cfg_q.max_speed   <= $signed(cfg.wr_data);
				default: ;
			endcase
		end
	end

	assign item.front_left_err  = sensor.front_left_err;
	assign item.front_right_err = sensor.front_right_err;
	assign item.rear_left_err   = sensor.rear_left_err;
	assign item.rear_right_err  = sensor.rear_right_err;
	assign item.forward_dir     = sensor.forward_dir;
	assign item.nominal_speed   = sensor.nominal_speed;
	assign sensor.ready         = item_ready;

	assign slot_free = !out_valid_q || wheel.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (res_valid && slot_free)
			out_valid_q <= 1'b1;
		else if (wheel.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (res_valid && slot_free) begin
			left_q  <= res.left_speed;
			right_q <= res.right_speed;
		end
	end

	assign wheel.valid       = out_valid_q;
	assign wheel.left_speed  = left_q;
	assign wheel.right_speed = right_q;

	wpdd_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.item_valid (sensor.valid),
		.item       (item),
		.item_ready (item_ready),
		.res_valid  (res_valid),
		.res        (res),
		.res_ready  (slot_free),
		.mul_req    (mul_req),
		.mul_done   (mul_done),
		.mul_prod   (mul_prod),
		.div_req    (div_req),
		.div_done   (div_done),
		.div_quot   (div_quot)
	);

	wpdd_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	wpdd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.quot   (div_quot)
	);

endmodule
